>>> hw/rtl/fsca_pkg.sv
// Shared types and constants of the sector chain allocator.
package fsca_pkg;

    localparam int unsigned SECTOR_W = 8;
    localparam int unsigned LIMIT_W  = 9;

    localparam logic [SECTOR_W-1:0] FAT_FREE   = 8'h00;
    localparam logic [SECTOR_W-1:0] FAT_LAST   = 8'hff;
    localparam logic [SECTOR_W-1:0] DISK_RESET = 8'd255;
    localparam logic [SECTOR_W-1:0] NO_SECTOR  = 8'd0;

    typedef enum logic
    {
        OP_ALLOC  = 1'b0,
        OP_FORMAT = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_LINK,
        ST_RESULT
    } state_t;

endpackage

>>> hw/rtl/fsca_req_if.sv
// Request channel: operation and chain tail to link from.
interface fsca_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [fsca_pkg::SECTOR_W-1:0] previous_sector;

    modport source (output valid, output op, output previous_sector, input ready);
    modport sink   (input valid, input op, input previous_sector, output ready);
endinterface

>>> hw/rtl/fsca_rsp_if.sv
// Response channel: allocated sector and full flag.
interface fsca_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsca_pkg::SECTOR_W-1:0] allocated_sector;
    logic                          full_res;

    modport source (output valid, output allocated_sector, output full_res, input ready);
    modport sink   (input valid, input allocated_sector, input full_res, output ready);
endinterface

>>> hw/rtl/fat_sector_chain_allocator.sv
// Sector chain allocator over an 8-bit file allocation table held in a synchronous memory.
//
// Requests arrive on req (op, previous_sector) and each one gives exactly one transfer on
// rsp (allocated_sector, full_res). A valid/ready pair moves a transfer on each channel.
// cfg_wr_en/cfg_wr_data write the disk size register; write it only while the block is idle.
//
// Allocate reads the table one entry per cycle from entry 1 upward, visiting up to
// min(disk size, TABLE_ENTRIES) - 1 entries, then marks the new sector as last and,
// when a link is due, writes the link. A format walks all TABLE_ENTRIES entries through
// the single write port.
// The read latency of the table memory sets the scan rate of one entry per cycle.
//
// After reset the block runs the same clearing pass (entry 0 gets the disk size) and
// holds req.ready low until it ends. A finished result sits in an output register, so the
// next request is taken while the receiver stalls; a further result then waits in the
// engine until the output register frees up.
module fat_sector_chain_allocator #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fsca_pkg::SECTOR_W-1:0] cfg_wr_data,
    fsca_req_if.sink                      req,
    fsca_rsp_if.source                    rsp
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] PTR_LAST  = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] PTR_FIRST = CW'(1);
    localparam logic [fsca_pkg::LIMIT_W-1:0] ENTRY_LIMIT = fsca_pkg::LIMIT_W'(TABLE_ENTRIES);

    logic [fsca_pkg::SECTOR_W-1:0] table_mem [TABLE_ENTRIES];
    logic [fsca_pkg::SECTOR_W-1:0] rd_data_reg;

    fsca_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                 ptr_reg, ptr_next;
    logic [fsca_pkg::SECTOR_W-1:0] prev_reg, prev_next;
    logic                          fmt_reg, fmt_next;
    logic [fsca_pkg::SECTOR_W-1:0] res_sector_reg, res_sector_next;
    logic                          res_full_reg, res_full_next;
    logic [fsca_pkg::SECTOR_W-1:0] disk_reg;
    logic                          out_valid_reg;
    logic [fsca_pkg::SECTOR_W-1:0] out_sector_reg;
    logic                          out_full_reg;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [fsca_pkg::SECTOR_W-1:0] mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic                          load_out;
    logic                          req_fire;

    logic [fsca_pkg::LIMIT_W-1:0]  limit;
    logic [CW-1:0]                 ptr_inc;
    logic                          scan_end;
    logic                          link_ok;
    logic                          out_free;

    // The scan covers entries below min(disk size, TABLE_ENTRIES).
    assign limit    = ({1'b0, disk_reg} >= ENTRY_LIMIT) ? ENTRY_LIMIT : {1'b0, disk_reg};
    assign ptr_inc  = ptr_reg + CW'(1);
    assign scan_end = (fsca_pkg::LIMIT_W'(ptr_inc) >= limit);
    assign link_ok  = (prev_reg != fsca_pkg::NO_SECTOR) && ({1'b0, prev_reg} < limit);
    assign out_free = !out_valid_reg || rsp.ready;
    assign req_fire = req.valid && req.ready;

    assign req.ready            = (state_reg == fsca_pkg::ST_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.allocated_sector = out_sector_reg;
    assign rsp.full_res         = out_full_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsca_pkg::ST_CLEAR:
            begin
                if (ptr_reg == PTR_LAST)
                begin
                    state_next = fmt_reg ? fsca_pkg::ST_RESULT : fsca_pkg::ST_IDLE;
                end
            end
            fsca_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == fsca_pkg::OP_FORMAT)
                    begin
                        state_next = fsca_pkg::ST_CLEAR;
                    end
                    else if (limit <= fsca_pkg::LIMIT_W'(1))
                    begin
                        state_next = fsca_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = fsca_pkg::ST_SCAN;
                    end
                end
            end
            fsca_pkg::ST_SCAN:
            begin
                if (rd_data_reg == fsca_pkg::FAT_FREE)
                begin
                    state_next = fsca_pkg::ST_MARK;
                end
                else if (scan_end)
                begin
                    state_next = fsca_pkg::ST_RESULT;
                end
            end
            fsca_pkg::ST_MARK:
            begin
                state_next = link_ok ? fsca_pkg::ST_LINK : fsca_pkg::ST_RESULT;
            end
            fsca_pkg::ST_LINK:
            begin
                state_next = fsca_pkg::ST_RESULT;
            end
            fsca_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = fsca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fsca_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses and datapath updates.
    always_comb
    begin
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        fmt_next        = fmt_reg;
        res_sector_next = res_sector_reg;
        res_full_next   = res_full_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[AW-1:0];
        mem_wdata       = fsca_pkg::FAT_FREE;
        mem_raddr       = ptr_inc[AW-1:0];
        load_out        = 1'b0;
        case (state_reg)
            fsca_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (ptr_reg == '0) ? disk_reg : fsca_pkg::FAT_FREE;
                ptr_next  = ptr_inc;
            end
            fsca_pkg::ST_IDLE:
            begin
                mem_raddr = PTR_FIRST[AW-1:0];
                if (req_fire)
                begin
                    prev_next       = req.previous_sector;
                    ptr_next        = (req.op == fsca_pkg::OP_FORMAT) ? '0 : PTR_FIRST;
                    fmt_next        = (req.op == fsca_pkg::OP_FORMAT);
                    res_sector_next = fsca_pkg::NO_SECTOR;
                    // A disk of fewer than two sectors has nothing to scan.
                    res_full_next   = (req.op == fsca_pkg::OP_ALLOC)
                                      && (limit <= fsca_pkg::LIMIT_W'(1));
                end
            end
            fsca_pkg::ST_SCAN:
            begin
                if (rd_data_reg == fsca_pkg::FAT_FREE)
                begin
                    res_sector_next = fsca_pkg::SECTOR_W'(ptr_reg);
                end
                else if (scan_end)
                begin
                    res_full_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            fsca_pkg::ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = fsca_pkg::FAT_LAST;
            end
            fsca_pkg::ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = prev_reg[AW-1:0];
                mem_wdata = res_sector_reg;
            end
            fsca_pkg::ST_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsca_pkg::ST_CLEAR;
            ptr_reg       <= '0;
            fmt_reg       <= 1'b0;
            disk_reg      <= fsca_pkg::DISK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            fmt_reg   <= fmt_next;
            if (cfg_wr_en)
            begin
                disk_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        res_sector_reg <= res_sector_next;
        res_full_reg   <= res_full_next;
        if (load_out)
        begin
            out_sector_reg <= res_sector_reg;
            out_full_reg   <= res_full_reg;
        end
    end

endmodule
